### rtl/assert_macros.svh
// Assertion macros shared by the query parameter decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define QPD_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define QPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/qpd_pkg.sv
// Types, constants and helper functions of the query parameter decoder.
package qpd_pkg;

   // Default and absolute limit of the name length.
   localparam int MAX_NAME_DEF = 16;
   localparam int NAME_CHARS   = 16;
   localparam int NAME_LEN_W   = 5;
   localparam int CHARS_W      = 64;
   localparam int BYTE_W       = 8;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NAME_LENGTH     = 2'd0,
      CSR_NAME_CHARS_LOW  = 2'd1,
      CSR_NAME_CHARS_HIGH = 2'd2
   } csr_index_type;

   // Result queue depth; two free slots are needed to take an item.
   localparam int QUEUE_DEPTH = 4;

   // Characters with a special meaning in a query string.
   localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;
   localparam logic [BYTE_W-1:0] CH_EQUAL   = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
   localparam logic [BYTE_W-1:0] CH_DIGIT0  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_DIGIT9  = 8'h39;
   // 'A' minus ten: maps 'A' to 'F' onto ten to fifteen; bytes below 55 wrap.
   localparam logic [BYTE_W-1:0] HEX_ALPHA_BIAS = 8'd55;

   // Parsing phase of the current string.
   typedef enum logic [5:0] {
      PH_SEARCH       = 6'b000001,
      PH_EXPECT       = 6'b000010,
      PH_VALUE        = 6'b000100,
      PH_DONE_FOUND   = 6'b001000,
      PH_DONE_MISSING = 6'b010000,
      PH_ENDED        = 6'b100000
   } phase_type;

   // Progress through a percent escape.
   typedef enum logic [1:0] {
      ESC_NONE = 2'b00,
      ESC_HIGH = 2'b01,
      ESC_LOW  = 2'b10
   } esc_type;

   // Configuration register contents.
   typedef struct packed {
      logic [NAME_LEN_W-1:0] name_length;
      logic [CHARS_W-1:0]    name_chars_low;
      logic [CHARS_W-1:0]    name_chars_high;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              found;
      logic              last;
   } res_type;

   // Results of one accepted byte: an optional value byte, then an optional status.
   typedef struct packed {
      logic              data_valid;
      logic [BYTE_W-1:0] data_byte;
      logic              status_valid;
      logic              status_found;
   } step_type;

   // Hex digit value, uppercase only, wrapping modulo 256 for other bytes.
   function automatic logic [BYTE_W-1:0] hex_value(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] v;
      if (b >= CH_DIGIT0 && b <= CH_DIGIT9) begin
         v = b - CH_DIGIT0;
      end else begin
         v = b - HEX_ALPHA_BIAS;
      end
      return v;
   endfunction

   // Name character i taken from the two character registers.
   function automatic logic [BYTE_W-1:0] name_char(input cfg_type cfg,
                                                  input logic [3:0] i);
      logic [2*CHARS_W-1:0] all_chars;
      all_chars = {cfg.name_chars_high, cfg.name_chars_low};
      return all_chars[{i, 3'b000} +: BYTE_W];
   endfunction

endpackage

### rtl/qpd_req_if.sv
// Input channel: one query string byte per transfer.
interface qpd_req_if;
   logic                      valid;
   logic                      ready;
   logic [qpd_pkg::BYTE_W-1:0] in_byte;
   logic                      frame_end;

   modport source (output valid, output in_byte, output frame_end, input ready);
   modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

### rtl/qpd_rsp_if.sv
// Result channel: decoded value bytes and the closing status item.
interface qpd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [qpd_pkg::BYTE_W-1:0] out_byte;
   logic                      found;
   logic                      last;

   modport source (output valid, output out_byte, output found, output last, input ready);
   modport sink   (input valid, input out_byte, input found, input last, output ready);
endinterface

### rtl/query_param_extract_url_decode.sv
// Top level of the query parameter extractor with percent decoding.
//
// Usage: the query string enters on req_ch one byte per transfer, with
// frame_end on its last byte; a zero byte also ends the string. The value
// of the first occurrence of the configured name (followed by '=') leaves
// on rsp_ch one decoded byte per transfer, and every string closes with a
// status transfer (last set, found telling whether the name was present).
// The name and its length are written through the csr_ port while idle.
// A result is registered in the queue when its byte is accepted, then offered.
// Input: one byte per cycle while req_ch.ready is high; single-stage decoder.
// A byte may yield two results (value byte and status); they drain through
// a four-entry result queue, and req_ch.ready is high while at least two
// entries are free. When the receiver stalls, results wait in the queue and
// input stops once fewer than two entries are free.
// Reset clears the phase, the escape state, the queue and the registers
// (name length one, name characters zero).
module query_param_extract_url_decode #(
   parameter int MAX_NAME = qpd_pkg::MAX_NAME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [qpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qpd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   qpd_req_if.sink                         req_ch,
   qpd_rsp_if.source                       rsp_ch
);

   qpd_pkg::cfg_type  cfg_ff;
   qpd_pkg::step_type step;
   qpd_pkg::res_type  out_res;
   logic              q_ready;
   logic              accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.name_length     <= qpd_pkg::NAME_LEN_W'(1);
         cfg_ff.name_chars_low  <= '0;
         cfg_ff.name_chars_high <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            qpd_pkg::CSR_NAME_LENGTH:
               cfg_ff.name_length <= csr_wdata[qpd_pkg::NAME_LEN_W-1:0];
            qpd_pkg::CSR_NAME_CHARS_LOW:
               cfg_ff.name_chars_low <= csr_wdata[qpd_pkg::CHARS_W-1:0];
            qpd_pkg::CSR_NAME_CHARS_HIGH:
               cfg_ff.name_chars_high <= csr_wdata[qpd_pkg::CHARS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A byte transfers when the queue has room for both possible results.
   assign req_ch.ready = q_ready;
   assign accept       = req_ch.valid && q_ready;

   qpd_core #(
      .MAX_NAME (MAX_NAME)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .in_byte   (req_ch.in_byte),
      .frame_end (req_ch.frame_end),
      .step      (step)
   );

   qpd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_ready  (q_ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_res   (out_res)
   );

   assign rsp_ch.out_byte = out_res.out_byte;
   assign rsp_ch.found    = out_res.found;
   assign rsp_ch.last     = out_res.last;

endmodule

### rtl/qpd_core.sv
// Name search window, phase tracking and percent decoding, one byte per cycle while accept is high.
`include "assert_macros.svh"

module qpd_core #(
   parameter int MAX_NAME = qpd_pkg::MAX_NAME_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  qpd_pkg::cfg_type           cfg,
   input  logic                       accept,
   input  logic [qpd_pkg::BYTE_W-1:0] in_byte,
   input  logic                       frame_end,
   output qpd_pkg::step_type          step
);

   localparam int CNT_W = $clog2(MAX_NAME + 1);
   localparam int LW    = qpd_pkg::NAME_LEN_W;

   logic [qpd_pkg::BYTE_W-1:0] recent_ff [MAX_NAME];
   logic [qpd_pkg::BYTE_W-1:0] recent_in [MAX_NAME];
   logic [CNT_W-1:0]           seen_ff, seen_in;
   qpd_pkg::phase_type         phase_ff, phase_in, phase_mid;
   qpd_pkg::esc_type           esc_ff, esc_in;
   logic [3:0]                 esc_high_ff, esc_high_in;

   logic [LW-1:0]              eff_len;
   logic [CNT_W-1:0]           seen_next;
   logic                       match;
   logic [qpd_pkg::BYTE_W-1:0] hex_b;

   // Clamp the configured length into one to MAX_NAME.
   always_comb begin
      if (cfg.name_length == '0) begin
         eff_len = LW'(1);
      end else if (cfg.name_length > LW'(MAX_NAME)) begin
         eff_len = LW'(MAX_NAME);
      end else begin
         eff_len = cfg.name_length;
      end
   end

   // Shifted window and saturating fill count, as they stand after this byte.
   always_comb begin
      recent_in[0] = in_byte;
      for (int k = 1; k < MAX_NAME; k++) begin
         recent_in[k] = recent_ff[k-1];
      end
      seen_next = (seen_ff == CNT_W'(MAX_NAME)) ? seen_ff : seen_ff + CNT_W'(1);
   end

   // The newest byte closes the name when every live window position matches.
   always_comb begin
      logic [LW-1:0] idx;
      match = (LW'(seen_next) >= eff_len);
      for (int k = 0; k < MAX_NAME; k++) begin
         idx = eff_len - LW'(1) - LW'(k);
         if (LW'(k) < eff_len &&
             recent_in[k] != qpd_pkg::name_char(cfg, idx[3:0])) begin
            match = 1'b0;
         end
      end
   end

   assign hex_b = qpd_pkg::hex_value(in_byte);

   // Phase and escape update with the results of this byte.
   always_comb begin
      phase_mid   = phase_ff;
      phase_in    = phase_ff;
      esc_in      = esc_ff;
      esc_high_in = esc_high_ff;
      seen_in     = seen_ff;
      step        = '0;

      if (phase_ff == qpd_pkg::PH_ENDED) begin
         // Bytes after an early zero are dropped up to the frame end.
         if (frame_end) begin
            phase_in = qpd_pkg::PH_SEARCH;
         end
      end else if (in_byte == qpd_pkg::CH_NUL) begin
         // A zero byte ends the string at once.
         step.status_valid = 1'b1;
         step.status_found = (phase_ff == qpd_pkg::PH_VALUE) ||
                             (phase_ff == qpd_pkg::PH_DONE_FOUND);
         seen_in     = '0;
         esc_in      = qpd_pkg::ESC_NONE;
         esc_high_in = '0;
         phase_in    = frame_end ? qpd_pkg::PH_SEARCH : qpd_pkg::PH_ENDED;
      end else begin
         unique case (phase_ff)
            qpd_pkg::PH_SEARCH: begin
               seen_in = seen_next;
               if (match) begin
                  phase_mid = qpd_pkg::PH_EXPECT;
               end
            end
            qpd_pkg::PH_EXPECT: begin
               phase_mid = (in_byte == qpd_pkg::CH_EQUAL) ? qpd_pkg::PH_VALUE
                                                          : qpd_pkg::PH_DONE_MISSING;
            end
            qpd_pkg::PH_VALUE: begin
               priority if (esc_ff == qpd_pkg::ESC_HIGH) begin
                  esc_high_in = hex_b[3:0];
                  esc_in      = qpd_pkg::ESC_LOW;
               end else if (esc_ff == qpd_pkg::ESC_LOW) begin
                  step.data_valid = 1'b1;
                  step.data_byte  = {esc_high_ff, 4'b0000} + hex_b;
                  esc_in          = qpd_pkg::ESC_NONE;
               end else if (in_byte == qpd_pkg::CH_AMP) begin
                  phase_mid = qpd_pkg::PH_DONE_FOUND;
               end else if (in_byte == qpd_pkg::CH_PERCENT) begin
                  esc_in = qpd_pkg::ESC_HIGH;
               end else if (in_byte == qpd_pkg::CH_PLUS) begin
                  step.data_valid = 1'b1;
                  step.data_byte  = qpd_pkg::CH_SPACE;
               end else begin
                  step.data_valid = 1'b1;
                  step.data_byte  = in_byte;
               end
            end
            qpd_pkg::PH_DONE_FOUND,
            qpd_pkg::PH_DONE_MISSING,
            qpd_pkg::PH_ENDED: begin
            end
            default: begin
            end
         endcase
         phase_in = phase_mid;

         // The frame end closes the string after any value byte.
         if (frame_end) begin
            step.status_valid = 1'b1;
            step.status_found = (phase_mid == qpd_pkg::PH_VALUE) ||
                                (phase_mid == qpd_pkg::PH_DONE_FOUND);
            seen_in     = '0;
            esc_in      = qpd_pkg::ESC_NONE;
            esc_high_in = '0;
            phase_in    = qpd_pkg::PH_SEARCH;
         end
      end

      if (!accept) begin
         step = '0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= qpd_pkg::PH_SEARCH;
         esc_ff      <= qpd_pkg::ESC_NONE;
         esc_high_ff <= '0;
         seen_ff     <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         esc_ff      <= esc_in;
         esc_high_ff <= esc_high_in;
         seen_ff     <= seen_in;
      end
   end

   // Window bytes only count once the fill count covers them.
   always_ff @(posedge clock) begin
      if (accept && phase_ff == qpd_pkg::PH_SEARCH && in_byte != qpd_pkg::CH_NUL) begin
         for (int k = 0; k < MAX_NAME; k++) begin
            recent_ff[k] <= recent_in[k];
         end
      end
   end

   `QPD_ASSERT(a_data_in_value, clock, reset, step.data_valid, phase_ff == qpd_pkg::PH_VALUE, "value byte outside the value phase")
   `QPD_ASSERT(a_esc_in_value, clock, reset, esc_ff != qpd_pkg::ESC_NONE, phase_ff == qpd_pkg::PH_VALUE, "escape pending outside the value phase")

endmodule

### rtl/qpd_out_queue.sv
// Four-entry result queue taking up to two results per cycle and giving one.
`include "assert_macros.svh"

module qpd_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  qpd_pkg::step_type step,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output qpd_pkg::res_type  out_res
);

   localparam int DEPTH = qpd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   qpd_pkg::res_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         push_n;
   logic               pop;
   qpd_pkg::res_type   first_res, second_res, data_res, status_res;

   // Order the results: value byte first, status behind it.
   always_comb begin
      data_res   = '{out_byte: step.data_byte, found: 1'b0, last: 1'b0};
      status_res = '{out_byte: qpd_pkg::CH_NUL, found: step.status_found, last: 1'b1};
      first_res  = step.data_valid ? data_res : status_res;
      second_res = status_res;
      push_n     = {1'b0, step.data_valid} + {1'b0, step.status_valid};
   end

   assign in_ready  = (count_ff <= CNT_W'(DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_res   = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   // Pointer and fill count arithmetic.
   always_comb begin
      wr_in    = wr_ff + PTR_W'(push_n);
      rd_in    = rd_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= first_res;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ff + PTR_W'(1)] <= second_res;
      end
   end

   `QPD_ASSERT(a_no_overflow, clock, reset, push_n != 2'd0, count_ff <= CNT_W'(DEPTH - 2), "result pushed without two free slots")
   `QPD_ASSERT_NEXT(a_pop_count, clock, reset, pop && push_n == 2'd0, count_ff == $past(count_ff - CNT_W'(1)), "fill count did not follow a transfer")

endmodule
